>>> design/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// shared types for the segment intersection test pipeline
// ----------------------------------------------------------------------------
package sit_pkg;

   // side-of-line flags produced by the cross product stage
   typedef struct packed {
      logic degen;
      logic sc_neg;
      logic sd_neg;
      logic sa_neg;
      logic sa_pos;
      logic sb_neg;
      logic sb_pos;
   } side_flags_type;

endpackage

>>> design/sit_prep.sv
// ----------------------------------------------------------------------------
// sit_prep
// first stage: endpoint differences and degenerate segment detection
// ----------------------------------------------------------------------------
module sit_prep #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         load,
   input  logic signed [COORD_BITS-1:0] a_x,
   input  logic signed [COORD_BITS-1:0] a_y,
   input  logic signed [COORD_BITS-1:0] b_x,
   input  logic signed [COORD_BITS-1:0] b_y,
   input  logic signed [COORD_BITS-1:0] c_x,
   input  logic signed [COORD_BITS-1:0] c_y,
   input  logic signed [COORD_BITS-1:0] d_x,
   input  logic signed [COORD_BITS-1:0] d_y,
   output logic signed [COORD_BITS:0]   bx_ff,
   output logic signed [COORD_BITS:0]   by_ff,
   output logic signed [COORD_BITS:0]   cx_ff,
   output logic signed [COORD_BITS:0]   cy_ff,
   output logic signed [COORD_BITS:0]   dx_ff,
   output logic signed [COORD_BITS:0]   dy_ff,
   output logic signed [COORD_BITS:0]   ex_ff,
   output logic signed [COORD_BITS:0]   ey_ff,
   output logic signed [COORD_BITS:0]   gx_ff,
   output logic signed [COORD_BITS:0]   gy_ff,
   output logic                         degen_ff
);
   localparam int DW = COORD_BITS + 1;

   logic signed [DW-1:0] ax_w, ay_w, bx_w, by_w, cx_w, cy_w, dx_w, dy_w;
   logic                 degen_in;

   assign ax_w = {a_x[COORD_BITS-1], a_x};
   assign ay_w = {a_y[COORD_BITS-1], a_y};
   assign bx_w = {b_x[COORD_BITS-1], b_x};
   assign by_w = {b_y[COORD_BITS-1], b_y};
   assign cx_w = {c_x[COORD_BITS-1], c_x};
   assign cy_w = {c_y[COORD_BITS-1], c_y};
   assign dx_w = {d_x[COORD_BITS-1], d_x};
   assign dy_w = {d_y[COORD_BITS-1], d_y};

   // zero length or shared endpoint
   assign degen_in = (a_x == b_x && a_y == b_y) || (c_x == d_x && c_y == d_y) ||
                     (a_x == c_x && a_y == c_y) || (b_x == c_x && b_y == c_y) ||
                     (a_x == d_x && a_y == d_y) || (b_x == d_x && b_y == d_y);

   always_ff @(posedge clock) begin
      if (load) begin
         bx_ff    <= bx_w - ax_w;
         by_ff    <= by_w - ay_w;
         cx_ff    <= cx_w - ax_w;
         cy_ff    <= cy_w - ay_w;
         dx_ff    <= dx_w - ax_w;
         dy_ff    <= dy_w - ay_w;
         ex_ff    <= dx_w - cx_w;
         ey_ff    <= dy_w - cy_w;
         gx_ff    <= bx_w - cx_w;
         gy_ff    <= by_w - cy_w;
         degen_ff <= degen_in;
      end
   end

endmodule

>>> design/sit_mult.sv
// ----------------------------------------------------------------------------
// sit_mult
// second stage: the eight products of the four cross products
// ----------------------------------------------------------------------------
module sit_mult #(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic signed [COORD_BITS:0]     bx,
   input  logic signed [COORD_BITS:0]     by,
   input  logic signed [COORD_BITS:0]     cx,
   input  logic signed [COORD_BITS:0]     cy,
   input  logic signed [COORD_BITS:0]     dx,
   input  logic signed [COORD_BITS:0]     dy,
   input  logic signed [COORD_BITS:0]     ex,
   input  logic signed [COORD_BITS:0]     ey,
   input  logic signed [COORD_BITS:0]     gx,
   input  logic signed [COORD_BITS:0]     gy,
   input  logic                           degen,
   output logic signed [2*COORD_BITS+1:0] sc1_ff,
   output logic signed [2*COORD_BITS+1:0] sc2_ff,
   output logic signed [2*COORD_BITS+1:0] sd1_ff,
   output logic signed [2*COORD_BITS+1:0] sd2_ff,
   output logic signed [2*COORD_BITS+1:0] sa1_ff,
   output logic signed [2*COORD_BITS+1:0] sa2_ff,
   output logic signed [2*COORD_BITS+1:0] sb1_ff,
   output logic signed [2*COORD_BITS+1:0] sb2_ff,
   output logic                           degen_ff
);
   localparam int PW = 2 * COORD_BITS + 2;

   logic signed [PW-1:0] sc1_in, sc2_in, sd1_in, sd2_in;
   logic signed [PW-1:0] sa1_in, sa2_in, sb1_in, sb2_in;

   // sc, sd: sides of c and d against line ab; sa, sb: sides of a and b against cd
   assign sc1_in = PW'(bx) * PW'(cy);
   assign sc2_in = PW'(by) * PW'(cx);
   assign sd1_in = PW'(bx) * PW'(dy);
   assign sd2_in = PW'(by) * PW'(dx);
   assign sa1_in = PW'(ey) * PW'(cx);
   assign sa2_in = PW'(ex) * PW'(cy);
   assign sb1_in = PW'(ex) * PW'(gy);
   assign sb2_in = PW'(ey) * PW'(gx);

   always_ff @(posedge clock) begin
      if (load) begin
         sc1_ff   <= sc1_in;
         sc2_ff   <= sc2_in;
         sd1_ff   <= sd1_in;
         sd2_ff   <= sd2_in;
         sa1_ff   <= sa1_in;
         sa2_ff   <= sa2_in;
         sb1_ff   <= sb1_in;
         sb2_ff   <= sb2_in;
         degen_ff <= degen;
      end
   end

endmodule

>>> design/sit_side.sv
// ----------------------------------------------------------------------------
// sit_side
// third stage: cross product differences reduced to sign flags
// ----------------------------------------------------------------------------
module sit_side #(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           load,
   input  logic signed [2*COORD_BITS+1:0] sc1,
   input  logic signed [2*COORD_BITS+1:0] sc2,
   input  logic signed [2*COORD_BITS+1:0] sd1,
   input  logic signed [2*COORD_BITS+1:0] sd2,
   input  logic signed [2*COORD_BITS+1:0] sa1,
   input  logic signed [2*COORD_BITS+1:0] sa2,
   input  logic signed [2*COORD_BITS+1:0] sb1,
   input  logic signed [2*COORD_BITS+1:0] sb2,
   input  logic                           degen,
   output sit_pkg::side_flags_type        flags_ff
);
   import sit_pkg::*;

   localparam int PW = 2 * COORD_BITS + 2;
   localparam int SW = PW + 1;

   logic signed [SW-1:0] sc_w, sd_w, sa_w, sb_w;
   side_flags_type       flags_in;

   assign sc_w = {sc1[PW-1], sc1} - {sc2[PW-1], sc2};
   assign sd_w = {sd1[PW-1], sd1} - {sd2[PW-1], sd2};
   assign sa_w = {sa1[PW-1], sa1} - {sa2[PW-1], sa2};
   assign sb_w = {sb1[PW-1], sb1} - {sb2[PW-1], sb2};

   always_comb begin
      flags_in.degen  = degen;
      flags_in.sc_neg = sc_w[SW-1];
      flags_in.sd_neg = sd_w[SW-1];
      flags_in.sa_neg = sa_w[SW-1];
      flags_in.sa_pos = !sa_w[SW-1] && (sa_w != '0);
      flags_in.sb_neg = sb_w[SW-1];
      flags_in.sb_pos = !sb_w[SW-1] && (sb_w != '0);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff <= flags_in;
      end
   end

endmodule

>>> design/segment_intersection_test_top.sv
// ----------------------------------------------------------------------------
// segment_intersection_test_top
// 2d segment crossing test, four register stages, without result stalls one pair per cycle
// ----------------------------------------------------------------------------
// Takes one segment pair per cycle while the result side does not stall and
// returns one crosses bit per pair, in order. Each pair passes through the
// four register stages: endpoint differences, the eight (2*COORD_BITS+2)-bit
// products, the cross product signs, and the output register. The crossing is
// decided exactly from the signs of the four cross products: c and d split by
// line ab (on ab counts as positive), and a and b on opposite sides of, or on,
// line cd. Zero length segments and shared endpoints give 0. Stalls hold each
// stage in place and empty stages fill behind a stall.
module segment_intersection_test_top #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic signed [COORD_BITS-1:0] req_c_x,
   input  logic signed [COORD_BITS-1:0] req_c_y,
   input  logic signed [COORD_BITS-1:0] req_d_x,
   input  logic signed [COORD_BITS-1:0] req_d_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_crosses
);
   import sit_pkg::*;

   localparam int PW = 2 * COORD_BITS + 2;

   logic signed [COORD_BITS:0] bx, by, cx, cy, dx, dy, ex, ey, gx, gy;
   logic signed [PW-1:0]       sc1, sc2, sd1, sd2, sa1, sa2, sb1, sb2;
   logic                       degen1, degen2;
   side_flags_type             flags;

   logic v1_ff, v2_ff, v3_ff, vo_ff;
   logic v1_in, v2_in, v3_in, vo_in;
   logic ld1, ld2, ld3, ldo;
   logic crosses_ff, crosses_in;

   // a stage loads when it is empty or its contents move on
   assign ldo = !vo_ff || rsp_ready;
   assign ld3 = !v3_ff || ldo;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;

   assign req_ready = ld1;

   always_comb begin
      v1_in = ld1 ? req_valid : v1_ff;
      v2_in = ld2 ? v1_ff     : v2_ff;
      v3_in = ld3 ? v2_ff     : v3_ff;
      vo_in = ldo ? v3_ff     : vo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   sit_prep #(.COORD_BITS(COORD_BITS)) u_prep (
      .clock    (clock),
      .load     (ld1),
      .a_x      (req_a_x),
      .a_y      (req_a_y),
      .b_x      (req_b_x),
      .b_y      (req_b_y),
      .c_x      (req_c_x),
      .c_y      (req_c_y),
      .d_x      (req_d_x),
      .d_y      (req_d_y),
      .bx_ff    (bx),
      .by_ff    (by),
      .cx_ff    (cx),
      .cy_ff    (cy),
      .dx_ff    (dx),
      .dy_ff    (dy),
      .ex_ff    (ex),
      .ey_ff    (ey),
      .gx_ff    (gx),
      .gy_ff    (gy),
      .degen_ff (degen1)
   );

   sit_mult #(.COORD_BITS(COORD_BITS)) u_mult (
      .clock    (clock),
      .load     (ld2),
      .bx       (bx),
      .by       (by),
      .cx       (cx),
      .cy       (cy),
      .dx       (dx),
      .dy       (dy),
      .ex       (ex),
      .ey       (ey),
      .gx       (gx),
      .gy       (gy),
      .degen    (degen1),
      .sc1_ff   (sc1),
      .sc2_ff   (sc2),
      .sd1_ff   (sd1),
      .sd2_ff   (sd2),
      .sa1_ff   (sa1),
      .sa2_ff   (sa2),
      .sb1_ff   (sb1),
      .sb2_ff   (sb2),
      .degen_ff (degen2)
   );

   sit_side #(.COORD_BITS(COORD_BITS)) u_side (
      .clock    (clock),
      .load     (ld3),
      .sc1      (sc1),
      .sc2      (sc2),
      .sd1      (sd1),
      .sd2      (sd2),
      .sa1      (sa1),
      .sa2      (sa2),
      .sb1      (sb1),
      .sb2      (sb2),
      .degen    (degen2),
      .flags_ff (flags)
   );

   // c and d split (on ab counts as positive), a and b not strictly on the same side of cd
   assign crosses_in = !flags.degen && (flags.sc_neg != flags.sd_neg) &&
                       !(flags.sa_pos && flags.sb_pos) &&
                       !(flags.sa_neg && flags.sb_neg);

   always_ff @(posedge clock) begin
      if (ldo) begin
         crosses_ff <= crosses_in;
      end
   end

   assign rsp_valid   = vo_ff;
   assign rsp_crosses = crosses_ff;

endmodule

>>> design/sit_checker.sv
// ----------------------------------------------------------------------------
// sit_checker
// port level checks on the segment intersection test, bound to the top level
// ----------------------------------------------------------------------------
module sit_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_crosses
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_crosses))
      else $error("stalled result changed");

   // an empty output register means the pipeline can take a transfer
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with output empty");

   // a draining output never stalls the input
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind segment_intersection_test_top sit_checker u_sit_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_crosses (rsp_crosses)
);

>>> tb/tb_segment_intersection_test_top.sv
// ----------------------------------------------------------------------------
// tb_segment_intersection_test_top
// self-checking testbench for the 2d segment crossing test
// ----------------------------------------------------------------------------
// Drives segment pairs through the valid/ready request channel and checks
// every crosses bit against an exact 128-bit model of the crossing rules:
// zero length and shared endpoints give 0, c and d must be split by line ab
// (on ab as positive), the crossing must lie within a-b, both ends included.
// Directed tests cover the edge rules and the coordinate extremes; random
// tests mix full-range, small-grid, extreme-value and constructed crossing
// pairs. Both channels idle at random, with stretches of full throughput.
// ----------------------------------------------------------------------------
module tb_segment_intersection_test_top;

   localparam int COORD_BITS = 16;
   localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [127:0]          wide_type;

   typedef struct packed {
      coord_type ax, ay, bx, by, cx, cy, dx, dy;
   } seg_pair_type;

   typedef struct {
      seg_pair_type pair;
      bit           crosses;
   } crossing_check_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   coord_type req_a_x = '0, req_a_y = '0, req_b_x = '0, req_b_y = '0;
   coord_type req_c_x = '0, req_c_y = '0, req_d_x = '0, req_d_y = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   logic      rsp_crosses;

   crossing_check_type pending_crossings[$];
   crossing_check_type head_check;
   int                 error_count = 0;
   int                 stall_left = 0;
   int                 stall_pick = 0;
   bit                 steady = 1'b0;

   segment_intersection_test_top #(
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_a_x     (req_a_x),
      .req_a_y     (req_a_y),
      .req_b_x     (req_b_x),
      .req_b_y     (req_b_y),
      .req_c_x     (req_c_x),
      .req_c_y     (req_c_y),
      .req_d_x     (req_d_x),
      .req_d_y     (req_d_y),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_crosses (rsp_crosses)
   );

   always #5 clock = ~clock;

   // exact crossing decision, no division
   function automatic bit pair_crosses(seg_pair_type p);
      wide_type ax, ay, bx, by, cx, cy, dx, dy;
      wide_type sc, sd, dotc, dotd, len2, num, den, lim;
      if ((p.ax == p.bx && p.ay == p.by) || (p.cx == p.dx && p.cy == p.dy))
         return 1'b0;
      if ((p.ax == p.cx && p.ay == p.cy) || (p.bx == p.cx && p.by == p.cy) ||
          (p.ax == p.dx && p.ay == p.dy) || (p.bx == p.dx && p.by == p.dy))
         return 1'b0;
      ax = $signed(p.ax);
      ay = $signed(p.ay);
      bx = $signed(p.bx) - ax;
      by = $signed(p.by) - ay;
      cx = $signed(p.cx) - ax;
      cy = $signed(p.cy) - ay;
      dx = $signed(p.dx) - ax;
      dy = $signed(p.dy) - ay;
      sc = bx * cy - by * cx;
      sd = bx * dy - by * dx;
      if ((sc < 0) == (sd < 0))
         return 1'b0;
      dotc = bx * cx + by * cy;
      dotd = bx * dx + by * dy;
      len2 = bx * bx + by * by;
      num  = dotc * sd - dotd * sc;
      den  = sd - sc;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num < 0)
         return 1'b0;
      lim = len2 * den;
      return !(lim < num);
   endfunction

   function automatic seg_pair_type make_pair(int ax, int ay, int bx, int by,
                                              int cx, int cy, int dx, int dy);
      seg_pair_type p;
      p.ax = coord_type'(ax);
      p.ay = coord_type'(ay);
      p.bx = coord_type'(bx);
      p.by = coord_type'(by);
      p.cx = coord_type'(cx);
      p.cy = coord_type'(cy);
      p.dx = coord_type'(dx);
      p.dy = coord_type'(dy);
      return p;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic send_pair(seg_pair_type p);
      crossing_check_type chk;
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_a_x   <= p.ax;
      req_a_y   <= p.ay;
      req_b_x   <= p.bx;
      req_b_y   <= p.by;
      req_c_x   <= p.cx;
      req_c_y   <= p.cy;
      req_d_x   <= p.dx;
      req_d_y   <= p.dy;
      chk.pair    = p;
      chk.crosses = pair_crosses(p);
      pending_crossings.push_back(chk);
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // result side: check each transfer, then choose the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_crossings.size() == 0) begin
               report_mismatch($sformatf("result %0b with nothing expected", rsp_crosses));
            end else begin
               head_check = pending_crossings.pop_front();
               if (rsp_crosses !== head_check.crosses)
                  report_mismatch($sformatf(
                     "a(%0d,%0d) b(%0d,%0d) c(%0d,%0d) d(%0d,%0d) crosses %b expected %b",
                     head_check.pair.ax, head_check.pair.ay,
                     head_check.pair.bx, head_check.pair.by,
                     head_check.pair.cx, head_check.pair.cy,
                     head_check.pair.dx, head_check.pair.dy,
                     rsp_crosses, head_check.crosses));
            end
         end
         if (steady) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else begin
            stall_pick = pick_gap();
            rsp_ready  <= (stall_pick == 0);
            if (stall_pick > 0)
               stall_left <= stall_pick - 1;
         end
      end
   end

   task automatic test_basic_crossing();
      send_pair(make_pair(-10, 0, 10, 0, 0, -10, 0, 10));
      send_pair(make_pair(3, 7, -5, -2, -4, 6, 2, -3));
   endtask

   task automatic test_zero_length();
      send_pair(make_pair(5, 5, 5, 5, 0, 0, 10, 10));
      send_pair(make_pair(-10, 0, 10, 0, 0, 0, 0, 0));
      send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                          COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
   endtask

   task automatic test_shared_endpoints();
      send_pair(make_pair(0, 0, 10, 10, 0, 0, 10, -10));
      send_pair(make_pair(0, 0, 10, 10, -5, 20, 10, 10));
      send_pair(make_pair(0, 0, 10, 10, 10, 10, 0, 0));
      send_pair(make_pair(-4, 4, 4, -4, 7, 1, -4, 4));
   endtask

   task automatic test_point_on_line();
      // c on ab with d above: no split
      send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, 5));
      // c on ab with d below: split, crossing at c
      send_pair(make_pair(0, 0, 10, 0, 5, 0, 5, -5));
      send_pair(make_pair(0, 0, 10, 0, 5, 5, 5, 0));
      // collinear overlap and parallel
      send_pair(make_pair(0, 0, 10, 0, 2, 0, 8, 0));
      send_pair(make_pair(0, 0, 10, 0, 2, 1, 8, 1));
   endtask

   task automatic test_endpoint_crossing();
      send_pair(make_pair(0, 0, 10, 0, 0, -5, 0, 5));
      send_pair(make_pair(0, 0, 10, 0, 10, 5, 10, -5));
      send_pair(make_pair(0, 0, 10, 0, 20, -5, 20, 5));
      send_pair(make_pair(0, 0, 10, 0, -1, -5, -1, 5));
      send_pair(make_pair(0, 0, 10, 0, 4, 1, 6, 9));
   endtask

   task automatic test_extreme_coords();
      send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                          COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
      send_pair(make_pair(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                          COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
      send_pair(make_pair(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                          COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN));
      send_pair(make_pair(COORD_MIN, 0, COORD_MAX, -1,
                          0, COORD_MIN, -1, COORD_MAX));
   endtask

   task automatic test_random_full_range(int count);
      for (int i = 0; i < count; i++) begin
         steady <= (i % 150) < 25;
         send_pair(make_pair($urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom));
      end
   endtask

   // tiny grid: many collinear, shared and zero length pairs
   task automatic test_random_small_grid(int count);
      for (int i = 0; i < count; i++) begin
         steady <= (i % 120) < 20;
         send_pair(make_pair($urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                             $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                             $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3,
                             $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3));
      end
   endtask

   task automatic test_random_extreme_values(int count);
      int vals[7] = '{COORD_MIN, COORD_MIN + 1, -1, 0, 1, COORD_MAX - 1, COORD_MAX};
      for (int i = 0; i < count; i++) begin
         steady <= (i % 100) < 15;
         send_pair(make_pair(vals[$urandom_range(0, 6)], vals[$urandom_range(0, 6)],
                             vals[$urandom_range(0, 6)], vals[$urandom_range(0, 6)],
                             vals[$urandom_range(0, 6)], vals[$urandom_range(0, 6)],
                             vals[$urandom_range(0, 6)], vals[$urandom_range(0, 6)]));
      end
   endtask

   // pairs built around a common point m, including touching and near misses
   task automatic test_random_constructed(int count);
      int mx, my, ux, uy, vx, vy, s, w, span;
      seg_pair_type p;
      for (int i = 0; i < count; i++) begin
         steady <= (i % 150) < 25;
         mx   = $urandom_range(0, 32767) - 16384;
         my   = $urandom_range(0, 32767) - 16384;
         span = $urandom_range(0, 3) == 0 ? 3 : 4000;
         ux   = $urandom_range(0, 2 * span) - span;
         uy   = $urandom_range(0, 2 * span) - span;
         vx   = $urandom_range(0, 2 * span) - span;
         vy   = $urandom_range(0, 2 * span) - span;
         s    = $urandom_range(0, 3);
         w    = $urandom_range(0, 3);
         if ($urandom_range(0, 1))
            p = make_pair(mx - ux, my - uy, mx + s * ux, my + s * uy,
                          mx - vx, my - vy, mx + w * vx, my + w * vy);
         else
            p = make_pair(mx - vx, my - vy, mx + w * vx, my + w * vy,
                          mx - ux, my - uy, mx + s * ux, my + s * uy);
         if ($urandom_range(0, 3) == 0) begin
            p.dx = p.dx + coord_type'($urandom_range(0, 2) - 1);
            p.dy = p.dy + coord_type'($urandom_range(0, 2) - 1);
         end
         send_pair(p);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_crossing();
      test_zero_length();
      test_shared_endpoints();
      test_point_on_line();
      test_endpoint_crossing();
      test_extreme_coords();
      test_random_full_range(400);
      test_random_small_grid(350);
      test_random_extreme_values(200);
      test_random_constructed(600);
      req_valid <= 1'b0;
      steady    <= 1'b0;
      while (pending_crossings.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #30000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> files.f
design/sit_pkg.sv
design/sit_prep.sv
design/sit_mult.sv
design/sit_side.sv
design/segment_intersection_test_top.sv
design/sit_checker.sv
tb/tb_segment_intersection_test_top.sv
